FILE: hw/rtl/psl_pkg.sv
// Shared types, field widths and IEEE single-precision helpers for the
// pruning site likelihood step. No dependencies.
package psl_pkg;
	localparam int NumStates = 4;
	localparam int WordW = 32;
	localparam int MatDepth = NumStates * NumStates;
	localparam int InDataW = 264;
	localparam int OutDataW = NumStates * WordW;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;
	localparam logic SEL_LEFT = 1'b0;
	localparam logic SEL_RIGHT = 1'b1;

	localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
	localparam logic [31:0] QNAN_BIT = 32'h0040_0000;

	typedef logic [WordW-1:0] word_t;
	typedef word_t [NumStates-1:0] vec_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} psl_en_t;

	function automatic logic fp_is_nan(input word_t x);
		return (x[30:23] == 8'hFF) && (x[22:0] != 23'h0);
	endfunction

	function automatic logic fp_is_inf(input word_t x);
		return (x[30:23] == 8'hFF) && (x[22:0] == 23'h0);
	endfunction

	function automatic logic fp_is_zero(input word_t x);
		return x[30:0] == 31'h0;
	endfunction

	// Rounds a value 1.f * 2^(e-127) held with its leading one at bit 49 to
	// nearest even, with gradual underflow and overflow to infinity.
	function automatic word_t fp_round(input logic sgn, input logic signed [11:0] e,
			input logic [49:0] m);
		logic [11:0] sh;
		logic [49:0] ms;
		logic stk;
		logic signed [11:0] eb;
		logic signed [11:0] eo;
		logic [24:0] mant;
		logic rnd;
		word_t r;
		if (e <= 12'sd0) begin
			sh = 12'(12'sd1 - e);
			eb = 12'sd1;
		end else begin
			sh = 12'd0;
			eb = e;
		end
		if (sh >= 12'd50) begin
			ms = '0;
			stk = |m;
		end else begin
			ms = m >> sh;
			stk = |(m & ~({50{1'b1}} << sh));
		end
		rnd = ms[25] && (stk || (|ms[24:0]) || ms[26]);
		mant = {1'b0, ms[49:26]} + 25'(rnd);
		if (mant[24]) begin
			eo = eb + 12'sd1;
		end else if (mant[23]) begin
			eo = eb;
		end else begin
			eo = 12'sd0;
		end
		if (eo >= 12'sd255) begin
			r = {sgn, 8'hFF, 23'h0};
		end else begin
			r = {sgn, eo[7:0], mant[24] ? 23'h0 : mant[22:0]};
		end
		return r;
	endfunction

	function automatic word_t fp_mul(input word_t a, input word_t b);
		logic sgn;
		logic [7:0] ea;
		logic [7:0] eb;
		logic [23:0] ma;
		logic [23:0] mb;
		logic [47:0] p;
		logic [5:0] lz;
		logic found;
		logic [49:0] norm;
		logic signed [11:0] e;
		word_t r;
		sgn = a[31] ^ b[31];
		ea = (a[30:23] == 8'h0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'h0) ? 8'd1 : b[30:23];
		ma = {a[30:23] != 8'h0, a[22:0]};
		mb = {b[30:23] != 8'h0, b[22:0]};
		p = ma * mb;
		lz = '0;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found) begin
				if (p[i]) found = 1'b1;
				else lz = lz + 6'd1;
			end
		end
		norm = {p, 2'b00} << lz;
		e = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd126 - $signed({6'b0, lz});
		if (fp_is_nan(a)) begin
			r = a | QNAN_BIT;
		end else if (fp_is_nan(b)) begin
			r = b | QNAN_BIT;
		end else if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b))) begin
			r = QNAN_DEFAULT;
		end else if (fp_is_inf(a) || fp_is_inf(b)) begin
			r = {sgn, 8'hFF, 23'h0};
		end else if (fp_is_zero(a) || fp_is_zero(b)) begin
			r = {sgn, 31'h0};
		end else begin
			r = fp_round(sgn, e, norm);
		end
		return r;
	endfunction

	function automatic word_t fp_add(input word_t a, input word_t b);
		word_t x;
		word_t y;
		logic [7:0] ex;
		logic [7:0] ey;
		logic [7:0] d;
		logic [50:0] mx;
		logic [50:0] my0;
		logic [50:0] my;
		logic [50:0] sum;
		logic [50:0] norm;
		logic [5:0] lz;
		logic found;
		logic signed [11:0] e;
		word_t r;
		if (a[30:0] >= b[30:0]) begin
			x = a;
			y = b;
		end else begin
			x = b;
			y = a;
		end
		ex = (x[30:23] == 8'h0) ? 8'd1 : x[30:23];
		ey = (y[30:23] == 8'h0) ? 8'd1 : y[30:23];
		d = ex - ey;
		mx = {1'b0, x[30:23] != 8'h0, x[22:0], 26'h0};
		my0 = {1'b0, y[30:23] != 8'h0, y[22:0], 26'h0};
		if (d >= 8'd51) begin
			my = 51'(|my0);
		end else begin
			my = (my0 >> d) | 51'(|(my0 & ~({51{1'b1}} << d)));
		end
		sum = (x[31] ^ y[31]) ? (mx - my) : (mx + my);
		lz = '0;
		found = 1'b0;
		for (int i = 50; i >= 0; i--) begin
			if (!found) begin
				if (sum[i]) found = 1'b1;
				else lz = lz + 6'd1;
			end
		end
		norm = sum << lz;
		e = $signed({4'b0, ex}) + 12'sd1 - $signed({6'b0, lz});
		if (fp_is_nan(a)) begin
			r = a | QNAN_BIT;
		end else if (fp_is_nan(b)) begin
			r = b | QNAN_BIT;
		end else if (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31])) begin
			r = QNAN_DEFAULT;
		end else if (fp_is_inf(a)) begin
			r = a;
		end else if (fp_is_inf(b)) begin
			r = b;
		end else if (fp_is_zero(a) && fp_is_zero(b)) begin
			r = {a[31] & b[31], 31'h0};
		end else if (fp_is_zero(a)) begin
			r = b;
		end else if (fp_is_zero(b)) begin
			r = a;
		end else if (sum == 51'h0) begin
			r = '0;
		end else begin
			r = fp_round(x[31], e, {norm[50:2], norm[1] | norm[0]});
		end
		return r;
	endfunction
endpackage

FILE: hw/rtl/psl_lane.sv
// One parent-state lane: two four-term dot products and their product,
// in five registered stages. Depends on psl_pkg.
module psl_lane (
	input  logic              clk,
	input  psl_pkg::psl_en_t  en,
	input  psl_pkg::vec_t     row_l,
	input  psl_pkg::vec_t     row_r,
	input  psl_pkg::vec_t     vec_l,
	input  psl_pkg::vec_t     vec_r,
	output psl_pkg::word_t    result
);
	import psl_pkg::*;

	vec_t pl_s1;
	vec_t pr_s1;
	word_t al_s2;
	word_t ar_s2;
	word_t pl2_s2;
	word_t pr2_s2;
	word_t pl3_s2;
	word_t pr3_s2;
	word_t al_s3;
	word_t ar_s3;
	word_t pl3_s3;
	word_t pr3_s3;
	word_t al_s4;
	word_t ar_s4;
	word_t prod_s5;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int i = 0; i < NumStates; i++) begin
				pl_s1[i] <= fp_mul(row_l[i], vec_l[i]);
				pr_s1[i] <= fp_mul(row_r[i], vec_r[i]);
			end
		end
		if (en.s2) begin
			al_s2 <= fp_add(pl_s1[0], pl_s1[1]);
			ar_s2 <= fp_add(pr_s1[0], pr_s1[1]);
			pl2_s2 <= pl_s1[2];
			pr2_s2 <= pr_s1[2];
			pl3_s2 <= pl_s1[3];
			pr3_s2 <= pr_s1[3];
		end
		if (en.s3) begin
			al_s3 <= fp_add(al_s2, pl2_s2);
			ar_s3 <= fp_add(ar_s2, pr2_s2);
			pl3_s3 <= pl3_s2;
			pr3_s3 <= pr3_s2;
		end
		if (en.s4) begin
			al_s4 <= fp_add(al_s3, pl3_s3);
			ar_s4 <= fp_add(ar_s3, pr3_s3);
		end
		if (en.s5) begin
			prod_s5 <= fp_mul(al_s4, ar_s4);
		end
	end

	assign result = prod_s5;
endmodule

FILE: hw/rtl/pruning_site_likelihood_step.sv
// Top level of the pruning site likelihood step: matrix store, four lanes,
// stage valids and the merged result port. Depends on psl_pkg and psl_lane.
//
// Channel   Dir  Width           Contents
// s_*       in   tdata 264       one load or one site
// m_*       out  tdata 128       parent likelihoods of one site
//
// Each compute transfer yields its result after the five float stages of each
// lane, one site per cycle sustained while the output is not stalled.
// A load transfer writes its word at acceptance and yields nothing.
// Reset clears both matrices and all stage valids.
// A stalled output holds its stage; bubbles ahead of it still fill.
module pruning_site_likelihood_step (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// entry_index, left_prob_0..3, right_prob_0..3, zero fill
	input  logic [psl_pkg::InDataW-1:0]  s_tdata,
	// operation, matrix_select
	input  logic [1:0]                   s_tuser,
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// parent_prob_0..3
	output logic [psl_pkg::OutDataW-1:0] m_tdata,
	output logic                         m_tlast
);
	import psl_pkg::*;

	word_t left_q [MatDepth];
	word_t right_q [MatDepth];
	logic [4:0] valid_q;
	logic [4:0] last_q;
	psl_en_t en;
	logic accept;
	logic [3:0] idx;
	vec_t vec_l;
	vec_t vec_r;
	word_t res [NumStates];

	assign en.s5 = !valid_q[4] || m_tready;
	assign en.s4 = !valid_q[3] || en.s5;
	assign en.s3 = !valid_q[2] || en.s4;
	assign en.s2 = !valid_q[1] || en.s3;
	assign en.s1 = !valid_q[0] || en.s2;
	assign s_tready = en.s1;
	assign accept = s_tvalid && s_tready;
	assign idx = s_tdata[3:0];

	always_comb begin
		for (int i = 0; i < NumStates; i++) begin
			vec_l[i] = s_tdata[4 + WordW*i +: WordW];
			vec_r[i] = s_tdata[4 + WordW*(NumStates+i) +: WordW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MatDepth; i++) begin
				left_q[i] <= '0;
				right_q[i] <= '0;
			end
		end else if (accept && s_tuser[0] == OP_LOAD) begin
			if (s_tuser[1] == SEL_LEFT) left_q[idx] <= vec_l[0];
			else right_q[idx] <= vec_l[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			last_q <= '0;
		end else begin
			if (en.s1) begin
				valid_q[0] <= accept && s_tuser[0] == OP_COMPUTE;
				last_q[0] <= s_tlast;
			end
			if (en.s2) begin
				valid_q[1] <= valid_q[0];
				last_q[1] <= last_q[0];
			end
			if (en.s3) begin
				valid_q[2] <= valid_q[1];
				last_q[2] <= last_q[1];
			end
			if (en.s4) begin
				valid_q[3] <= valid_q[2];
				last_q[3] <= last_q[2];
			end
			if (en.s5) begin
				valid_q[4] <= valid_q[3];
				last_q[4] <= last_q[3];
			end
		end
	end

	for (genvar k = 0; k < NumStates; k++) begin : g_lane
		vec_t row_l;
		vec_t row_r;
		always_comb begin
			for (int j = 0; j < NumStates; j++) begin
				row_l[j] = left_q[NumStates*k + j];
				row_r[j] = right_q[NumStates*k + j];
			end
		end
		psl_lane u_lane (
			.clk    (clk),
			.en     (en),
			.row_l  (row_l),
			.row_r  (row_r),
			.vec_l  (vec_l),
			.vec_r  (vec_r),
			.result (res[k])
		);
		assign m_tdata[WordW*k +: WordW] = res[k];
	end

	assign m_tvalid = valid_q[4];
	assign m_tlast = last_q[4];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	a_compute_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser[0] == OP_COMPUTE |=> valid_q[0])
		else $error("accepted site did not enter the lanes");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser[0] == OP_LOAD |=> !valid_q[0])
		else $error("load produced a result");

	a_load_write: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser[0] == OP_LOAD && s_tuser[1] == SEL_LEFT
		|=> left_q[$past(idx)] == $past(vec_l[0]))
		else $error("left matrix word not written");
endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pruning_site_likelihood_step: matrix word loads
// and site computations checked against a bit-exact single-precision predictor.
// Depends on psl_pkg and the block's RTL.
module tb;
	import psl_pkg::*;

	typedef struct {
		logic       op;
		logic       sel;
		logic [3:0] idx;
		word_t      lp [4];
		word_t      rp [4];
		logic       last;
		logic       fixed;
		word_t      want [4];
	} site_item_t;

	typedef struct {
		word_t p [4];
		logic  last;
	} parent_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic [1:0]          s_tuser;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;
	logic                m_tlast;

	word_t      left_words [16];
	word_t      right_words [16];
	parent_t    parent_q [$];
	site_item_t plan [$];
	int         errors;
	int         results_seen;
	bit         hold_done;

	pruning_site_likelihood_step dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#5ms;
		$display("** pruning_site_likelihood_step: FAILED **");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h, expected %h", what, got, want);
		errors++;
	endtask

	// Rounds sign * m * 2^e to the nearest single, ties to even.
	function automatic word_t round_single(input logic s, input logic [127:0] m, input int e);
		int msb;
		int shift;
		int e0;
		int biased;
		logic [127:0] q;
		logic [127:0] rem;
		logic [127:0] half;
		msb = 0;
		for (int i = 0; i < 128; i++) begin
			if (m[i]) msb = i;
		end
		shift = msb - 23;
		if (-149 - e > shift) shift = -149 - e;
		if (shift > 127) begin
			q = '0;
		end else if (shift > 0) begin
			q = m >> shift;
			rem = m & ((128'(1) << shift) - 128'(1));
			half = 128'(1) << (shift - 1);
			if (rem > half || (rem == half && q[0])) q = q + 128'(1);
		end else begin
			q = m << (-shift);
		end
		e0 = e + shift;
		if (q[24]) begin
			q = q >> 1;
			e0++;
		end
		if (q[23]) begin
			biased = e0 + 150;
			if (biased >= 255) return {s, 8'hFF, 23'h0};
			return {s, biased[7:0], q[22:0]};
		end
		return {s, 8'h00, q[22:0]};
	endfunction

	function automatic logic is_nan(input word_t x);
		return x[30:23] == 8'hFF && x[22:0] != 0;
	endfunction

	function automatic logic is_inf(input word_t x);
		return x[30:23] == 8'hFF && x[22:0] == 0;
	endfunction

	function automatic logic [23:0] sig_of(input word_t x);
		return {x[30:23] != 0, x[22:0]};
	endfunction

	function automatic int lsb_exp(input word_t x);
		return (x[30:23] == 0) ? -149 : int'(x[30:23]) - 150;
	endfunction

	function automatic word_t single_mul(input word_t a, input word_t b);
		logic s;
		s = a[31] ^ b[31];
		if (is_nan(a)) return a | 32'h0040_0000;
		if (is_nan(b)) return b | 32'h0040_0000;
		if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return QNAN_DEFAULT;
		if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'h0};
		if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'h0};
		return round_single(s, 128'(sig_of(a)) * 128'(sig_of(b)), lsb_exp(a) + lsb_exp(b));
	endfunction

	function automatic word_t single_add(input word_t a, input word_t b);
		word_t x;
		word_t y;
		int diff;
		int e;
		logic s;
		logic [127:0] mx;
		logic [127:0] my;
		logic [127:0] m;
		if (is_nan(a)) return a | 32'h0040_0000;
		if (is_nan(b)) return b | 32'h0040_0000;
		if (is_inf(a) && is_inf(b) && a[31] != b[31]) return QNAN_DEFAULT;
		if (is_inf(a)) return a;
		if (is_inf(b)) return b;
		if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'h0};
		if (lsb_exp(a) >= lsb_exp(b)) begin
			x = a;
			y = b;
		end else begin
			x = b;
			y = a;
		end
		diff = lsb_exp(x) - lsb_exp(y);
		if (diff <= 80) begin
			mx = 128'(sig_of(x)) << diff;
			my = 128'(sig_of(y));
			e = lsb_exp(y);
		end else begin
			mx = 128'(sig_of(x)) << 3;
			my = 128'(sig_of(y) != 0);
			e = lsb_exp(x) - 3;
		end
		if (x[31] == y[31]) begin
			m = mx + my;
			s = x[31];
		end else if (mx >= my) begin
			m = mx - my;
			s = x[31];
		end else begin
			m = my - mx;
			s = y[31];
		end
		if (m == 0) return 32'h0;
		return round_single(s, m, e);
	endfunction

	function automatic word_t row_sum(input word_t mat [16], input int row, input word_t v [4]);
		word_t acc;
		acc = single_mul(mat[row * 4], v[0]);
		for (int i = 1; i < 4; i++) acc = single_add(acc, single_mul(mat[row * 4 + i], v[i]));
		return acc;
	endfunction

	task automatic predict_transfer(input site_item_t it);
		parent_t r;
		if (it.op == OP_LOAD) begin
			if (it.sel == SEL_LEFT) left_words[it.idx] = it.lp[0];
			else right_words[it.idx] = it.lp[0];
		end else begin
			for (int k = 0; k < 4; k++) begin
				r.p[k] = single_mul(row_sum(left_words, k, it.lp), row_sum(right_words, k, it.rp));
				if (it.fixed && r.p[k] !== it.want[k]) report("typed expectation", r.p[k], it.want[k]);
			end
			r.last = it.last;
			parent_q.push_back(r);
		end
	endtask

	function automatic word_t rand_word();
		int pick;
		word_t specials [10];
		specials = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
			32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFFFF_FFFF};
		pick = $urandom_range(0, 99);
		if (pick < 75) return {1'b0, 8'($urandom_range(110, 127)), 23'($urandom)};
		if (pick < 85) return $urandom;
		if (pick < 93) return specials[$urandom_range(0, 9)];
		return {1'($urandom), 8'($urandom_range(0, 3)), 23'($urandom)};
	endfunction

	function automatic site_item_t make_item(input logic op, input logic sel, input logic [3:0] idx,
			input word_t l, input word_t r, input logic last);
		site_item_t it;
		it.op = op;
		it.sel = sel;
		it.idx = idx;
		for (int i = 0; i < 4; i++) begin
			it.lp[i] = l;
			it.rp[i] = r;
			it.want[i] = 32'h0;
		end
		it.last = last;
		it.fixed = 1'b0;
		return it;
	endfunction

	function automatic site_item_t random_item();
		site_item_t it;
		it = make_item($urandom_range(0, 99) < 80 ? OP_COMPUTE : OP_LOAD, 1'($urandom),
			4'($urandom), 32'h0, 32'h0, 1'($urandom));
		for (int i = 0; i < 4; i++) begin
			it.lp[i] = rand_word();
			it.rp[i] = rand_word();
		end
		return it;
	endfunction

	task automatic send(input site_item_t it);
		repeat ($urandom_range(0, 18)) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = {it.sel, it.op};
		s_tlast = it.last;
		s_tdata = {4'h0, it.rp[3], it.rp[2], it.rp[1], it.rp[0],
			it.lp[3], it.lp[2], it.lp[1], it.lp[0], it.idx};
		do @(posedge clk); while (!s_tready);
		predict_transfer(it);
	endtask

	initial begin
		m_tready = 1'b0;
		hold_done = 1'b0;
		results_seen = 0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && results_seen >= 300) begin
				hold_done = 1'b1;
				repeat (200) begin
					@(negedge clk);
					m_tready = 1'b0;
				end
			end else if ($urandom_range(0, 3) != 0) begin
				repeat ($urandom_range(0, 18)) begin
					@(negedge clk);
					m_tready = 1'b0;
				end
			end
			@(negedge clk);
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_seen++;
			if (parent_q.size() == 0) begin
				report("result with nothing pending", m_tdata[31:0], 32'h0);
			end else begin
				parent_t w;
				w = parent_q.pop_front();
				for (int k = 0; k < 4; k++) begin
					if (m_tdata[k * 32 +: 32] !== w.p[k])
						report($sformatf("parent_prob_%0d", k), m_tdata[k * 32 +: 32], w.p[k]);
				end
				if (m_tlast !== w.last) report("site_is_last", 32'(m_tlast), 32'(w.last));
			end
		end
	end

	initial begin
		site_item_t it;
		int waited;
		errors = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		for (int i = 0; i < 16; i++) begin
			left_words[i] = 32'h0;
			right_words[i] = 32'h0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Cleared matrices give positive zero for a site of all ones.
		it = make_item(OP_COMPUTE, SEL_RIGHT, 4'hF, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
		it.fixed = 1'b1;
		plan.push_back(it);
		plan.push_back(make_item(OP_COMPUTE, SEL_LEFT, 4'h0, 32'hFFFF_FFFF, 32'h7F80_0000, 1'b1));
		for (int k = 0; k < 4; k++) begin
			plan.push_back(make_item(OP_LOAD, SEL_LEFT, 4'(k * 5), 32'h3F80_0000, 32'hFFFF_FFFF, 1'b1));
		end
		plan.push_back(make_item(OP_LOAD, SEL_LEFT, 4'h3, 32'h8000_0000, 32'h0, 1'b0));
		plan.push_back(make_item(OP_LOAD, SEL_RIGHT, 4'h0, 32'h7F7F_FFFF, 32'h0, 1'b0));
		plan.push_back(make_item(OP_LOAD, SEL_RIGHT, 4'h5, 32'h0000_0001, 32'h0, 1'b0));
		plan.push_back(make_item(OP_LOAD, SEL_RIGHT, 4'hA, 32'h7F80_0000, 32'h0, 1'b0));
		plan.push_back(make_item(OP_LOAD, SEL_RIGHT, 4'hF, 32'hBF80_0000, 32'h0, 1'b0));
		plan.push_back(make_item(OP_COMPUTE, SEL_LEFT, 4'h0, 32'h3F80_0000, 32'h3F80_0000, 1'b0));
		plan.push_back(make_item(OP_COMPUTE, SEL_LEFT, 4'h0, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1));
		plan.push_back(make_item(OP_COMPUTE, SEL_LEFT, 4'h0, 32'h0000_0001, 32'h807F_FFFF, 1'b0));
		plan.push_back(make_item(OP_COMPUTE, SEL_LEFT, 4'h0, 32'h0, 32'h8000_0000, 1'b0));
		plan.push_back(make_item(OP_COMPUTE, SEL_LEFT, 4'h0, 32'h7F80_0001, 32'h3F00_0000, 1'b1));
		plan.push_back(make_item(OP_COMPUTE, SEL_LEFT, 4'h0, 32'hFF80_0000, 32'h7FC0_0000, 1'b0));
		plan.push_back(make_item(OP_COMPUTE, SEL_LEFT, 4'h0, 32'h3400_0000, 32'h0080_0000, 1'b0));
		plan.push_back(make_item(OP_LOAD, SEL_RIGHT, 4'hA, 32'h0, 32'h0, 1'b0));
		plan.push_back(make_item(OP_COMPUTE, SEL_RIGHT, 4'h0, 32'h4000_0000, 32'h7F80_0000, 1'b1));

		foreach (plan[i]) send(plan[i]);
		repeat (1030) send(random_item());
		@(negedge clk);
		s_tvalid = 1'b0;

		waited = 0;
		while (parent_q.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (errors == 0 && parent_q.size() == 0) begin
			$display("** pruning_site_likelihood_step: PASSED **");
		end else begin
			$display("** pruning_site_likelihood_step: FAILED **");
		end
		$finish;
	end
endmodule

FILE: files.f
hw/rtl/psl_pkg.sv
hw/rtl/psl_lane.sv
hw/rtl/pruning_site_likelihood_step.sv
test/tb.sv
